// File: rtl/core/assert_macros.svh
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is low
`define PT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define PT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/ptint_pkg.sv
// Constants and register codes of the tint pixel core
package ptint_pkg;

  localparam int CHANNEL_BITS_DEF = 16;

  localparam int DENS_W = 17;
  localparam logic [DENS_W-1:0] DENS_ONE = 17'd65536;

  // Rec.601 luma weights, Q0.16, summing to one
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  localparam int FILT_RED_RST   = 60395;
  localparam int FILT_GREEN_RST = 35466;
  localparam int FILT_BLUE_RST  = 0;
  localparam logic [DENS_W-1:0] DENSITY_RST = 17'd52429;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW_MIN = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_RED   = 3'd0,
    CFG_FILTER_GREEN = 3'd1,
    CFG_FILTER_BLUE  = 3'd2,
    CFG_DENSITY      = 3'd3,
    CFG_KEEP_LUMA    = 3'd4
  } cfg_idx_t;

endpackage

// File: rtl/core/ptint_if.sv
// Pixel channel interfaces: input word and result word
interface ptint_in_if #(parameter int N = ptint_pkg::CHANNEL_BITS_DEF);
  logic         valid;
  logic         ready;
  logic [N-1:0] red_in;
  logic [N-1:0] green_in;
  logic [N-1:0] blue_in;
  logic [N-1:0] alpha_in;
  logic         span_end_in;

  modport source(output valid, red_in, green_in, blue_in, alpha_in, span_end_in,
                 input ready);
  modport sink(input valid, red_in, green_in, blue_in, alpha_in, span_end_in,
               output ready);
endinterface

interface ptint_out_if #(parameter int N = ptint_pkg::CHANNEL_BITS_DEF);
  logic         valid;
  logic         ready;
  logic [N-1:0] red_out;
  logic [N-1:0] green_out;
  logic [N-1:0] blue_out;
  logic [N-1:0] alpha_out;
  logic         span_end_out;

  modport source(output valid, red_out, green_out, blue_out, alpha_out, span_end_out,
                 input ready);
  modport sink(input valid, red_out, green_out, blue_out, alpha_out, span_end_out,
               output ready);
endinterface

// File: rtl/core/photo_filter_tint_pixel_core.sv
// Top level of the tint pixel core: config registers, pipeline, output skid
//
//   channel  | direction | handshake        | word
//   in_pix   | in        | valid / ready    | red, green, blue, alpha, span end
//   out_pix  | out       | valid / ready    | red, green, blue, alpha, span end
//   cfg_*    | in        | cfg_we only      | index, data
//
// One pixel per clock while in_pix.ready is high. The two pull steps each rest on
// pipelined dividers of CHANNEL_BITS+2 stages.
// Synchronous active-low reset clears valid bits and config to defaults.
// A word that meets a stalled output parks in a skid register; in_pix.ready drops
// only while that skid holds a word, and the whole pipeline holds with it.
module photo_filter_tint_pixel_core #(
  parameter int CHANNEL_BITS = ptint_pkg::CHANNEL_BITS_DEF,
  parameter int CFG_DW = (CHANNEL_BITS > ptint_pkg::CFG_DW_MIN) ? CHANNEL_BITS
                                                                 : ptint_pkg::CFG_DW_MIN
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ptint_in_if.sink                        in_pix,
  ptint_out_if.source                     out_pix,
  input  logic                            cfg_we,
  input  logic [ptint_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]               cfg_data
);
  import ptint_pkg::*;

  localparam int N  = CHANNEL_BITS;
  localparam int SW = N + 1;
  localparam int XW = N + 2;
  localparam int OW = 4 * N + 1;
  localparam logic [N-1:0] FULL = '1;

  logic [N-1:0]        filt_red_r;
  logic [N-1:0]        filt_green_r;
  logic [N-1:0]        filt_blue_r;
  logic [DENS_W-1:0]   density_r;
  logic                keep_luma_r;
  logic [DENS_W-1:0]   dens_eff;

  logic                en;
  logic [N-1:0]        c_in [3];
  logic [N-1:0]        f_in [3];

  logic                b_vld;
  logic [N-1:0]        b_src [3];
  logic [N-1:0]        b_t [3];
  logic [SW-1:0]       b_side;

  logic                l_vld;
  logic signed [XW-1:0] l_x [3];
  logic [N-1:0]        l_lum;
  logic signed [XW-1:0] l_lo;
  logic signed [XW-1:0] l_hi;
  logic [SW-1:0]       l_side;

  logic                p1_vld;
  logic signed [XW-1:0] p1_x [3];
  logic [N-1:0]        p1_lum;
  logic signed [XW-1:0] p1_lo;
  logic signed [XW-1:0] p1_hi;
  logic [SW-1:0]       p1_side;

  logic                p2_vld;
  logic signed [XW-1:0] p2_x [3];
  logic [SW-1:0]       p2_side;

  logic [N-1:0]        cl [3];
  logic [OW-1:0]       word_c;
  logic [OW-1:0]       out_word_r;
  logic [OW-1:0]       skid_r;
  logic                out_vld_r;
  logic                skid_full_r;
  logic                load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_red_r   <= N'(FILT_RED_RST);
      filt_green_r <= N'(FILT_GREEN_RST);
      filt_blue_r  <= N'(FILT_BLUE_RST);
      density_r    <= DENSITY_RST;
      keep_luma_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FILTER_RED:   filt_red_r   <= cfg_data[N-1:0];
        CFG_FILTER_GREEN: filt_green_r <= cfg_data[N-1:0];
        CFG_FILTER_BLUE:  filt_blue_r  <= cfg_data[N-1:0];
        CFG_DENSITY:      density_r    <= cfg_data[DENS_W-1:0];
        CFG_KEEP_LUMA:    keep_luma_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign dens_eff = (density_r > DENS_ONE) ? DENS_ONE : density_r;

  assign en           = !skid_full_r;
  assign in_pix.ready = en;

  assign c_in[0] = in_pix.red_in;
  assign c_in[1] = in_pix.green_in;
  assign c_in[2] = in_pix.blue_in;
  assign f_in[0] = filt_red_r;
  assign f_in[1] = filt_green_r;
  assign f_in[2] = filt_blue_r;

  ptint_blend #(.N(N), .SW(SW)) u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_pix.valid),
    .c_i   (c_in),
    .f_i   (f_in),
    .dens_i(dens_eff),
    .side_i({in_pix.alpha_in, in_pix.span_end_in}),
    .vld_o (b_vld),
    .src_o (b_src),
    .t_o   (b_t),
    .side_o(b_side)
  );

  ptint_luma #(.N(N), .SW(SW)) u_luma (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (b_vld),
    .src_i (b_src),
    .t_i   (b_t),
    .keep_i(keep_luma_r),
    .side_i(b_side),
    .vld_o (l_vld),
    .x_o   (l_x),
    .lum_o (l_lum),
    .lo_o  (l_lo),
    .hi_o  (l_hi),
    .side_o(l_side)
  );

  // low side first, then high side with the hi from before either pull
  ptint_pull #(.N(N), .SW(SW), .MODE(0)) u_pull_lo (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (l_vld),
    .x_i   (l_x),
    .lum_i (l_lum),
    .lo_i  (l_lo),
    .hi_i  (l_hi),
    .side_i(l_side),
    .vld_o (p1_vld),
    .x_o   (p1_x),
    .lum_o (p1_lum),
    .lo_o  (p1_lo),
    .hi_o  (p1_hi),
    .side_o(p1_side)
  );

  ptint_pull #(.N(N), .SW(SW), .MODE(1)) u_pull_hi (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (p1_vld),
    .x_i   (p1_x),
    .lum_i (p1_lum),
    .lo_i  (p1_lo),
    .hi_i  (p1_hi),
    .side_i(p1_side),
    .vld_o (p2_vld),
    .x_o   (p2_x),
    .lum_o (),
    .lo_o  (),
    .hi_o  (),
    .side_o(p2_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p2_x[i] < 0) begin
        cl[i] = '0;
      end else if (p2_x[i] > $signed({2'b00, FULL})) begin
        cl[i] = FULL;
      end else begin
        cl[i] = p2_x[i][N-1:0];
      end
    end
  end

  assign word_c   = {cl[0], cl[1], cl[2], p2_side};
  assign load_out = !out_vld_r || out_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_pix.ready) begin
        out_vld_r   <= 1'b1;
        skid_full_r <= 1'b0;
      end
    end else if (load_out) begin
      out_vld_r <= p2_vld;
    end else if (p2_vld) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_pix.ready) begin
        out_word_r <= skid_r;
      end
    end else if (load_out) begin
      out_word_r <= word_c;
    end else if (p2_vld) begin
      skid_r <= word_c;
    end
  end

  assign out_pix.valid = out_vld_r;
  assign {out_pix.red_out, out_pix.green_out, out_pix.blue_out,
          out_pix.alpha_out, out_pix.span_end_out} = out_word_r;

endmodule

// File: rtl/core/ptint_div.sv
// Pipelined restoring divider, one quotient bit per stage
module ptint_div #(
  parameter int NUMW = 34,
  parameter int DENW = 17,
  parameter int QW   = 18
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NUMW-1:0] num_i,
  input  logic [DENW-1:0] den_i,
  output logic [QW-1:0]   q_o
);
  localparam int CW = DENW + QW;

  logic [CW-1:0]   rem_r [QW-1];
  logic [DENW-1:0] den_r [QW-1];
  logic [QW-1:0]   q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [CW-1:0]   rem_in;
    logic [DENW-1:0] den_in;
    logic [QW-1:0]   q_in;
    logic [CW-1:0]   sh;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in = CW'(num_i);
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign sh = CW'(den_in) << (QW - 1 - k);
    assign ge = rem_in >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_in | (ge ? (QW'(1) << (QW - 1 - k)) : '0);
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? rem_in - sh : rem_in;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign q_o = q_r[QW-1];

endmodule

// File: rtl/core/ptint_pull.sv
// Pull of out-of-range colours toward the luma (low side or high side)
module ptint_pull #(
  parameter int N    = ptint_pkg::CHANNEL_BITS_DEF,
  parameter int SW   = N + 1,
  parameter int MODE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic signed [N+1:0] x_i [3],
  input  logic [N-1:0]        lum_i,
  input  logic signed [N+1:0] lo_i,
  input  logic signed [N+1:0] hi_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic signed [N+1:0] x_o [3],
  output logic [N-1:0]        lum_o,
  output logic signed [N+1:0] lo_o,
  output logic signed [N+1:0] hi_o,
  output logic [SW-1:0]       side_o
);
  localparam int XW   = N + 2;
  localparam int DW   = N + 1;
  localparam int QW   = N + 2;
  localparam int NUMW = 2 * N + 2;
  localparam int PW   = 2 * N + 4;
  localparam int CARW = 5 * XW + N + SW + 1;
  localparam logic [N-1:0] FULL = '1;

  // stage A: offset from luma times scale
  logic                 apply;
  logic signed [XW:0]   lum_e;
  logic signed [XW:0]   den_s;
  logic [N-1:0]         fac;
  logic signed [XW:0]   diff_c [3];
  logic signed [PW-1:0] prod_c [3];
  logic signed [PW-1:0] prod_r [3];
  logic [DW-1:0]        den_a_r;

  // stage B: magnitude with rounding half
  logic [PW-1:0]        mag_c [3];
  logic [NUMW-1:0]      num_r [3];
  logic [DW-1:0]        den_b_r;
  logic [2:0]           neg_r [QW+1];

  logic [QW-1:0]        q_c [3];
  logic [CARW-1:0]      car_in;
  logic [CARW-1:0]      car_r [QW+2];
  logic                 vld_r [QW+2];

  logic signed [XW-1:0] cx [3];
  logic [N-1:0]         clum;
  logic signed [XW-1:0] clo;
  logic signed [XW-1:0] chi;
  logic [SW-1:0]        cside;
  logic                 capp;
  logic [N+3:0]         s_c [3];

  logic                 vld_out_r;
  logic signed [XW-1:0] x_r [3];
  logic [N-1:0]         lum_r;
  logic signed [XW-1:0] lo_r;
  logic signed [XW-1:0] hi_r;
  logic [SW-1:0]        side_r;

  assign lum_e = {3'b000, lum_i};
  assign apply = (MODE != 0) ? (hi_i > $signed({2'b00, FULL})) : (lo_i < 0);
  assign den_s = (MODE != 0) ? ({hi_i[XW-1], hi_i} - lum_e) : (lum_e - {lo_i[XW-1], lo_i});
  assign fac   = (MODE != 0) ? (FULL - lum_i) : lum_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_c[i] = {x_i[i][XW-1], x_i[i]} - lum_e;
      prod_c[i] = diff_c[i] * $signed({1'b0, fac});
      mag_c[i]  = prod_r[i][PW-1] ? PW'(-prod_r[i]) : PW'(prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= prod_c[i];
        num_r[i]  <= mag_c[i][NUMW-1:0] + NUMW'(den_a_r >> 1);
      end
      den_a_r  <= den_s[DW-1:0];
      den_b_r  <= den_a_r;
      neg_r[0] <= {prod_r[2][PW-1], prod_r[1][PW-1], prod_r[0][PW-1]};
      for (int j = 1; j <= QW; j++) begin
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    ptint_div #(.NUMW(NUMW), .DENW(DW), .QW(QW)) u_div (
      .clk  (clk),
      .en   (en),
      .num_i(num_r[i]),
      .den_i(den_b_r),
      .q_o  (q_c[i])
    );
  end

  // everything not needed by the divide waits alongside it
  assign car_in = {x_i[0], x_i[1], x_i[2], lum_i, lo_i, hi_i, side_i, apply};

  always_ff @(posedge clk) begin
    if (en) begin
      car_r[0] <= car_in;
      for (int j = 1; j < QW + 2; j++) begin
        car_r[j] <= car_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < QW + 2; j++) begin
        vld_r[j] <= 1'b0;
      end
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int j = 1; j < QW + 2; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
      vld_out_r <= vld_r[QW+1];
    end
  end

  assign {cx[0], cx[1], cx[2], clum, clo, chi, cside, capp} = car_r[QW+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_c[i] = neg_r[QW][i] ? ({4'b0000, clum} - {2'b00, q_c[i]})
                            : ({4'b0000, clum} + {2'b00, q_c[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x_r[i] <= capp ? $signed(s_c[i][XW-1:0]) : cx[i];
      end
      lum_r  <= clum;
      lo_r   <= clo;
      hi_r   <= chi;
      side_r <= cside;
    end
  end

  assign vld_o  = vld_out_r;
  assign x_o    = x_r;
  assign lum_o  = lum_r;
  assign lo_o   = lo_r;
  assign hi_o   = hi_r;
  assign side_o = side_r;

endmodule

// File: rtl/core/ptint_blend.sv
// Filter multiply and density blend, three stages
module ptint_blend #(
  parameter int N  = ptint_pkg::CHANNEL_BITS_DEF,
  parameter int SW = N + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [N-1:0]                  c_i [3],
  input  logic [N-1:0]                  f_i [3],
  input  logic [ptint_pkg::DENS_W-1:0]  dens_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          vld_o,
  output logic [N-1:0]                  src_o [3],
  output logic [N-1:0]                  t_o [3],
  output logic [SW-1:0]                 side_o
);
  import ptint_pkg::*;

  localparam int BW = N + DENS_W;
  localparam logic [N-1:0]   FULL = '1;
  localparam logic [2*N-1:0] HALF = (2 * N)'((1 << (N - 1)) - 1);
  localparam logic [BW-1:0]  RND  = BW'(32768);

  logic [2:0]        vld_r;
  logic [N-1:0]      c1_r [3];
  logic [N-1:0]      c2_r [3];
  logic [N-1:0]      c3_r [3];
  logic [2*N-1:0]    p_r [3];
  logic [N-1:0]      m_r [3];
  logic [BW-1:0]     w_r [3];
  logic [N-1:0]      t_r [3];
  logic [SW-1:0]     side_r [3];

  logic [DENS_W-1:0] dinv;
  logic [2*N-1:0]    x_c [3];
  logic [N:0]        r_c [3];
  logic [N:0]        q_c [3];
  logic [BW-1:0]     s_c [3];

  assign dinv = DENS_ONE - dens_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // divide by 2^N-1: quotient guess from the top half, then at most two fixes
      x_c[i] = p_r[i] + HALF;
      r_c[i] = {1'b0, x_c[i][N-1:0]} + {1'b0, x_c[i][2*N-1:N]};
      q_c[i] = {1'b0, x_c[i][2*N-1:N]} + (N+1)'(r_c[i] >= {1'b0, FULL})
             + (N+1)'(r_c[i] >= {FULL, 1'b0});
      s_c[i] = w_r[i] + BW'(m_r[i] * dens_i) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i]  <= c_i[i] * f_i[i];
        c1_r[i] <= c_i[i];
        m_r[i]  <= q_c[i][N-1:0];
        w_r[i]  <= BW'(c1_r[i] * dinv);
        c2_r[i] <= c1_r[i];
        t_r[i]  <= s_c[i][N+15:16];
        c3_r[i] <= c2_r[i];
      end
      side_r[0] <= side_i;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  assign vld_o  = vld_r[2];
  assign src_o  = c3_r;
  assign t_o    = t_r;
  assign side_o = side_r[2];

endmodule

// File: rtl/core/ptint_luma.sv
// Luma of source and tint, luma restore and range scan, three stages
module ptint_luma #(
  parameter int N  = ptint_pkg::CHANNEL_BITS_DEF,
  parameter int SW = N + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [N-1:0]        src_i [3],
  input  logic [N-1:0]        t_i [3],
  input  logic                keep_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic signed [N+1:0] x_o [3],
  output logic [N-1:0]        lum_o,
  output logic signed [N+1:0] lo_o,
  output logic signed [N+1:0] hi_o
  ,
  output logic [SW-1:0]       side_o
);
  import ptint_pkg::*;

  localparam int XW = N + 2;
  localparam int PW = N + 16;
  localparam int SUMW = N + 18;
  localparam logic [SUMW-1:0] RND = SUMW'(32768);

  logic [2:0]           vld_r;
  logic [PW-1:0]        ps_r [3];
  logic [PW-1:0]        pt_r [3];
  logic [N-1:0]         t1_r [3];
  logic [N-1:0]         t2_r [3];
  logic [N-1:0]         lum_r;
  logic [N-1:0]         lumt_r;
  logic [SW-1:0]        side_r [3];
  logic signed [XW-1:0] x_r [3];
  logic [N-1:0]         lum3_r;
  logic signed [XW-1:0] lo_r;
  logic signed [XW-1:0] hi_r;

  logic [15:0]          w [3];
  logic [SUMW-1:0]      sum_s;
  logic [SUMW-1:0]      sum_t;
  logic signed [XW-1:0] diff;
  logic signed [XW-1:0] f_c [3];
  logic signed [XW-1:0] lo_c;
  logic signed [XW-1:0] hi_c;

  assign w[0] = W_RED;
  assign w[1] = W_GREEN;
  assign w[2] = W_BLUE;

  assign sum_s = SUMW'(ps_r[0]) + SUMW'(ps_r[1]) + SUMW'(ps_r[2]) + RND;
  assign sum_t = SUMW'(pt_r[0]) + SUMW'(pt_r[1]) + SUMW'(pt_r[2]) + RND;

  // with luma kept off the offset is zero, so no channel leaves range
  assign diff = keep_i ? ($signed({2'b00, lum_r}) - $signed({2'b00, lumt_r})) : '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_c[i] = $signed({2'b00, t2_r[i]}) + diff;
    end
    lo_c = f_c[0];
    hi_c = f_c[0];
    for (int i = 1; i < 3; i++) begin
      if (f_c[i] < lo_c) lo_c = f_c[i];
      if (f_c[i] > hi_c) hi_c = f_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ps_r[i] <= w[i] * src_i[i];
        pt_r[i] <= w[i] * t_i[i];
        t1_r[i] <= t_i[i];
        t2_r[i] <= t1_r[i];
        x_r[i]  <= f_c[i];
      end
      lum_r     <= sum_s[N+15:16];
      lumt_r    <= sum_t[N+15:16];
      lum3_r    <= lum_r;
      lo_r      <= lo_c;
      hi_r      <= hi_c;
      side_r[0] <= side_i;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  assign vld_o  = vld_r[2];
  assign x_o    = x_r;
  assign lum_o  = lum3_r;
  assign lo_o   = lo_r;
  assign hi_o   = hi_r;
  assign side_o = side_r[2];

endmodule

// File: rtl/core/ptint_chk.sv
// Port checker for the tint pixel core and its bind
`include "assert_macros.svh"

module ptint_chk #(
  parameter int N = ptint_pkg::CHANNEL_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [N-1:0] out_red,
  input logic [N-1:0] out_alpha
);

  // a stalled word holds its red and alpha fields
  `PT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_alpha), "stalled output word changed")

  // input side only backs up behind a stalled output
  `PT_ASSERT(a_ready_drop, clk, rst_n, $fell(in_ready) |-> $past(out_valid && !out_ready), "ready fell without output stall")

  `PT_ASSERT(a_skid_needs_out, clk, rst_n, !in_ready |-> out_valid, "skid full while output empty")

  `PT_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid && in_ready, "reset did not clear pipeline")

endmodule

bind photo_filter_tint_pixel_core ptint_chk #(.N(CHANNEL_BITS)) u_ptint_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_pix.ready),
  .out_valid(out_pix.valid),
  .out_ready(out_pix.ready),
  .out_red  (out_pix.red_out),
  .out_alpha(out_pix.alpha_out)
);
